// ===== rtl/rmf_pkg.sv =====
// rmf_pkg.sv - shared constants, register codes and config struct
// for the rect mosaic 5x5 filter; no dependencies
package rmf_pkg;

  localparam int MAX_WIDTH   = 512;
  localparam int MAX_HEIGHT  = 512;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int MEM_AW      = $clog2(STORE_DEPTH);

  localparam int IDX_W      = 18;
  localparam int PIX_W      = 32;
  localparam int CH_W       = 8;
  localparam int NUM_CH     = 3;
  localparam int CFG_DIM_W  = 10;
  localparam int CFG_RECT_W = 9;
  localparam int IN_TDATA_W = 56;

  localparam int WDIM_W = $clog2(MAX_WIDTH + 1);
  localparam int HDIM_W = $clog2(MAX_HEIGHT + 1);
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);

  localparam int DIV_CNT_W = $clog2(IDX_W + 1);

  localparam int BLOCK = 5;
  localparam int BLK_W = $clog2(BLOCK);

  // floor(v / 5) = (v * DIV5_MUL) >> DIV5_SHIFT, exact for v below 2^18
  localparam int DIV5_MUL   = 209716;
  localparam int DIV5_SHIFT = 20;

  // floor(s / 25) = (s * AVG_MUL) >> AVG_SHIFT, exact for s below 43690
  localparam int CH_MAX    = 255;
  localparam int SUM_MAX   = BLOCK * BLOCK * CH_MAX;
  localparam int SUM_W     = $clog2(SUM_MAX + 1);
  localparam int AVG_MUL   = 10486;
  localparam int AVG_MW    = 14;
  localparam int AVG_SHIFT = 18;

  localparam int NUM_REGS = 6;
  localparam int REG_AW   = $clog2(NUM_REGS);
  localparam int APB_AW   = REG_AW + 2;
  localparam int APB_DW   = 32;

  typedef enum logic [REG_AW-1:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_RECT_LEFT    = 3'd2,
    REG_RECT_RIGHT   = 3'd3,
    REG_RECT_TOP     = 3'd4,
    REG_RECT_BOTTOM  = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [WDIM_W-1:0]     width;
    logic [HDIM_W-1:0]     height;
    logic [CFG_RECT_W-1:0] left;
    logic [CFG_RECT_W-1:0] right;
    logic [CFG_RECT_W-1:0] top;
    logic [CFG_RECT_W-1:0] bottom;
  } cfg_t;

endpackage

// ===== rtl/rmf_ram.sv =====
// rmf_ram.sv - generic single-port synchronous ram with registered read
// no dependencies
module rmf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/rmf_cfg.sv =====
// rmf_cfg.sv - apb register file for frame size and filter rectangle
// depends on rmf_pkg
module rmf_cfg (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [rmf_pkg::APB_AW-1:0] paddr,
  input  logic [rmf_pkg::APB_DW-1:0] pwdata,
  output logic [rmf_pkg::APB_DW-1:0] prdata,
  output logic                      pready,
  output rmf_pkg::cfg_t             cfg
);
  import rmf_pkg::*;

  logic [CFG_DIM_W-1:0]  frame_width_r, frame_height_r;
  logic [CFG_RECT_W-1:0] rect_left_r, rect_right_r, rect_top_r, rect_bottom_r;
  reg_idx_t              reg_idx;
  logic                  wr_en;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[APB_AW-1:2]);
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= CFG_DIM_W'(MAX_WIDTH);
      frame_height_r <= CFG_DIM_W'(MAX_HEIGHT);
      rect_left_r    <= '0;
      rect_right_r   <= CFG_RECT_W'(511);
      rect_top_r     <= '0;
      rect_bottom_r  <= CFG_RECT_W'(511);
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_FRAME_WIDTH:  frame_width_r  <= pwdata[CFG_DIM_W-1:0];
        REG_FRAME_HEIGHT: frame_height_r <= pwdata[CFG_DIM_W-1:0];
        REG_RECT_LEFT:    rect_left_r    <= pwdata[CFG_RECT_W-1:0];
        REG_RECT_RIGHT:   rect_right_r   <= pwdata[CFG_RECT_W-1:0];
        REG_RECT_TOP:     rect_top_r     <= pwdata[CFG_RECT_W-1:0];
        REG_RECT_BOTTOM:  rect_bottom_r  <= pwdata[CFG_RECT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_FRAME_WIDTH:  prdata = APB_DW'(frame_width_r);
      REG_FRAME_HEIGHT: prdata = APB_DW'(frame_height_r);
      REG_RECT_LEFT:    prdata = APB_DW'(rect_left_r);
      REG_RECT_RIGHT:   prdata = APB_DW'(rect_right_r);
      REG_RECT_TOP:     prdata = APB_DW'(rect_top_r);
      REG_RECT_BOTTOM:  prdata = APB_DW'(rect_bottom_r);
      default:          prdata = '0;
    endcase
  end

  // zero reads as one, oversize saturates
  always_comb begin
    if (frame_width_r == '0) begin
      cfg.width = WDIM_W'(1);
    end else if (32'(frame_width_r) > MAX_WIDTH) begin
      cfg.width = WDIM_W'(MAX_WIDTH);
    end else begin
      cfg.width = WDIM_W'(frame_width_r);
    end
    if (frame_height_r == '0) begin
      cfg.height = HDIM_W'(1);
    end else if (32'(frame_height_r) > MAX_HEIGHT) begin
      cfg.height = HDIM_W'(MAX_HEIGHT);
    end else begin
      cfg.height = HDIM_W'(frame_height_r);
    end
    cfg.left   = rect_left_r;
    cfg.right  = rect_right_r;
    cfg.top    = rect_top_r;
    cfg.bottom = rect_bottom_r;
  end

endmodule

// ===== rtl/rmf_div.sv =====
// rmf_div.sv - restoring divider, one quotient bit per cycle
// splits a raster index into row and column; depends on rmf_pkg
module rmf_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [rmf_pkg::IDX_W-1:0]  dividend,
  input  logic [rmf_pkg::WDIM_W-1:0] divisor,
  output logic                      done,
  output logic [rmf_pkg::IDX_W-1:0]  quo,
  output logic [rmf_pkg::WDIM_W-1:0] rem
);
  import rmf_pkg::*;

  logic [IDX_W-1:0]     quo_r;
  logic [WDIM_W-1:0]    rem_r, dvs_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 done_r;
  logic                 busy, ge;
  logic [WDIM_W:0]      trial, diff;

  assign busy  = (cnt_r != '0);
  assign trial = {rem_r, quo_r[IDX_W-1]};
  assign ge    = (trial >= {1'b0, dvs_r});
  assign diff  = trial - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy && (cnt_r == DIV_CNT_W'(1));
      if (start) begin
        cnt_r <= DIV_CNT_W'(IDX_W);
      end else if (busy) begin
        cnt_r <= cnt_r - DIV_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy) begin
      quo_r <= {quo_r[IDX_W-2:0], ge};
      rem_r <= ge ? diff[WDIM_W-1:0] : trial[WDIM_W-1:0];
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

// ===== rtl/rect_mosaic_5x5_filter_unit.sv =====
// rect_mosaic_5x5_filter_unit.sv - top level of the rect mosaic 5x5 filter
// depends on rmf_pkg, rmf_cfg, rmf_div, rmf_ram
//
// usage:
// in channel carries commands: tuser is the command (write pixel or read
// filtered pixel), tdata holds pixel_index and pixel_data. a write stores
// the word in the frame ram in the cycle it transfers and gives no result.
// a read gives one 32-bit result on the out channel: the stored word when
// the pixel lies outside the rectangle, else the per-channel rgb average of
// its aligned 5x5 block with edge clamping and the top byte zero.
// one command is worked on at a time. a read runs an 18-step iterative
// index divider, then either one ram read or 25 reads through the single
// ram port plus divide and pack; the input reopens as the result loads.
// the result sits in an output register; the next command is taken while
// it waits, and a later result waits for the receiver before it loads.
// the user writes registers over the apb port only while the block is
// idle; the block itself does not enforce this. reset clears control
// state and restores register defaults; the frame ram is not cleared, and
// a pixel never written reads as unknown.
module rect_mosaic_5x5_filter_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  // tdata: pixel_index [17:0], pixel_data [49:18], zero pad [55:50]
  input  logic [rmf_pkg::IN_TDATA_W-1:0] in_tdata,
  // tuser: command [0]
  input  logic                           in_tuser,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // tdata: filtered_pixel [31:0]
  output logic [rmf_pkg::PIX_W-1:0]      out_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rmf_pkg::APB_AW-1:0]     paddr,
  input  logic [rmf_pkg::APB_DW-1:0]     pwdata,
  output logic [rmf_pkg::APB_DW-1:0]     prdata,
  output logic                           pready
);
  import rmf_pkg::*;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_DIV  = 8'b0000_0010,
    S_MOD  = 8'b0000_0100,
    S_SCAN = 8'b0000_1000,
    S_LAST = 8'b0001_0000,
    S_PASS = 8'b0010_0000,
    S_PACK = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_t;

  cfg_t cfg;

  state_t                   state_r, state_nxt;
  logic [IDX_W-1:0]         idx_r, idx_nxt;
  logic [COL_W-1:0]         x0_r, x0_nxt;
  logic [IDX_W-1:0]         y0_r, y0_nxt;
  logic [BLK_W-1:0]         dx_r, dx_nxt, dy_r, dy_nxt;
  logic [NUM_CH-1:0][SUM_W-1:0] acc_r, acc_nxt;
  logic                     rd_vld_r;
  logic [PIX_W-1:0]         res_r, res_nxt;
  logic [PIX_W-1:0]         out_tdata_r, out_tdata_nxt;
  logic                     out_tvalid_r, out_tvalid_nxt;

  logic [IDX_W-1:0]  in_idx;
  logic [PIX_W-1:0]  in_pix;
  logic              in_xfer;

  logic              div_start, div_done;
  logic [IDX_W-1:0]  div_quo;
  logic [WDIM_W-1:0] div_rem;

  logic              ram_we;
  logic [MEM_AW-1:0] ram_addr;
  logic [PIX_W-1:0]  ram_rdata;

  logic [COL_W-1:0]            pos_x;
  logic [IDX_W-1:0]            pos_y;
  logic [COL_W+DIV5_SHIFT-1:0] x_prod;
  logic [IDX_W+DIV5_SHIFT-1:0] y_prod;
  logic [COL_W-1:0]            x_q5;
  logic [IDX_W-1:0]            y_q5;
  logic                        in_rect;

  logic [COL_W:0]            col_sum, col_lim;
  logic [IDX_W:0]            row_sum, row_lim;
  logic [COL_W-1:0]          col;
  logic [ROW_W-1:0]          row;
  logic [ROW_W+WDIM_W-1:0]   row_base;
  logic [ROW_W+WDIM_W:0]     scan_sum;
  logic [MEM_AW-1:0]         scan_addr;
  logic                      scan_end;

  logic [SUM_W+AVG_MW-1:0]   avg_prod [NUM_CH];
  logic [NUM_CH-1:0][CH_W-1:0] avg;

  assign in_idx  = in_tdata[IDX_W-1:0];
  assign in_pix  = in_tdata[IDX_W +: PIX_W];
  assign in_xfer = in_tvalid & in_tready;

  rmf_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign div_start = in_xfer && (in_tuser == CMD_READ);

  rmf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (in_idx),
    .divisor  (cfg.width),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  rmf_ram #(
    .WIDTH (PIX_W),
    .DEPTH (STORE_DEPTH)
  ) u_frame_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_pix),
    .rdata (ram_rdata)
  );

  // block origin and rectangle test
  assign pos_x  = div_rem[COL_W-1:0];
  assign pos_y  = div_quo;
  assign x_prod = (COL_W+DIV5_SHIFT)'(pos_x) * (COL_W+DIV5_SHIFT)'(DIV5_MUL);
  assign y_prod = (IDX_W+DIV5_SHIFT)'(pos_y) * (IDX_W+DIV5_SHIFT)'(DIV5_MUL);
  assign x_q5   = x_prod[DIV5_SHIFT +: COL_W];
  assign y_q5   = y_prod[DIV5_SHIFT +: IDX_W];
  assign in_rect = !((IDX_W'(pos_x) < IDX_W'(cfg.left))  ||
                     (IDX_W'(pos_x) > IDX_W'(cfg.right)) ||
                     (pos_y < IDX_W'(cfg.top))            ||
                     (pos_y > IDX_W'(cfg.bottom)));

  // clamped scan address
  assign col_sum  = (COL_W+1)'(x0_r) + (COL_W+1)'(dx_r);
  assign col_lim  = (COL_W+1)'(cfg.width - WDIM_W'(1));
  assign col      = COL_W'((col_sum > col_lim) ? col_lim : col_sum);
  assign row_sum  = (IDX_W+1)'(y0_r) + (IDX_W+1)'(dy_r);
  assign row_lim  = (IDX_W+1)'(cfg.height - HDIM_W'(1));
  assign row      = ROW_W'((row_sum > row_lim) ? row_lim : row_sum);
  assign row_base = (ROW_W+WDIM_W)'(row) * (ROW_W+WDIM_W)'(cfg.width);
  assign scan_sum = (ROW_W+WDIM_W+1)'(row_base) + (ROW_W+WDIM_W+1)'(col);
  assign scan_addr = MEM_AW'(scan_sum);
  assign scan_end = (dx_r == BLK_W'(BLOCK - 1)) && (dy_r == BLK_W'(BLOCK - 1));

  assign ram_we = in_xfer && (in_tuser == CMD_WRITE) && (32'(in_idx) < STORE_DEPTH);

  always_comb begin
    unique case (state_r)
      S_SCAN:  ram_addr = scan_addr;
      S_MOD:   ram_addr = MEM_AW'(idx_r);
      default: ram_addr = MEM_AW'(in_idx);
    endcase
  end

  // divide by 25 and pack
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      avg_prod[c] = (SUM_W+AVG_MW)'(acc_r[c]) * (SUM_W+AVG_MW)'(AVG_MUL);
      avg[c]      = avg_prod[c][AVG_SHIFT +: CH_W];
    end
  end

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    x0_nxt         = x0_r;
    y0_nxt         = y0_r;
    dx_nxt         = dx_r;
    dy_nxt         = dy_r;
    acc_nxt        = acc_r;
    res_nxt        = res_r;
    out_tdata_nxt  = out_tdata_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;

    if (rd_vld_r) begin
      for (int c = 0; c < NUM_CH; c++) begin
        acc_nxt[c] = acc_r[c] + SUM_W'(ram_rdata[c*CH_W +: CH_W]);
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (div_start) begin
          idx_nxt   = in_idx;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        x0_nxt  = COL_W'({x_q5, 2'b00}) + x_q5;
        y0_nxt  = IDX_W'({y_q5, 2'b00}) + y_q5;
        dx_nxt  = '0;
        dy_nxt  = '0;
        acc_nxt = '0;
        state_nxt = in_rect ? S_SCAN : S_PASS;
      end
      S_SCAN: begin
        if (dx_r == BLK_W'(BLOCK - 1)) begin
          dx_nxt = '0;
          dy_nxt = dy_r + BLK_W'(1);
        end else begin
          dx_nxt = dx_r + BLK_W'(1);
        end
        if (scan_end) begin
          state_nxt = S_LAST;
        end
      end
      S_LAST: begin
        state_nxt = S_PACK;
      end
      S_PASS: begin
        res_nxt   = (32'(idx_r) < STORE_DEPTH) ? ram_rdata : '0;
        state_nxt = S_OUT;
      end
      S_PACK: begin
        res_nxt   = {CH_W'(0), avg[2], avg[1], avg[0]};
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_tvalid_r || out_tready) begin
          out_tdata_nxt  = res_r;
          out_tvalid_nxt = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
      rd_vld_r     <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      rd_vld_r     <= (state_r == S_SCAN);
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    x0_r        <= x0_nxt;
    y0_r        <= y0_nxt;
    dx_r        <= dx_nxt;
    dy_r        <= dy_nxt;
    acc_r       <= acc_nxt;
    res_r       <= res_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  assign out_tdata  = out_tdata_r;
  assign out_tvalid = out_tvalid_r;

`ifndef SYNTHESIS
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider finished outside the divide state");

  a_pack_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PACK) |-> ($past(state_r) == S_LAST))
    else $error("pack entered without completing the block scan");

  a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PACK) |-> ((acc_r[0] <= SUM_W'(SUM_MAX)) &&
                             (acc_r[1] <= SUM_W'(SUM_MAX)) &&
                             (acc_r[2] <= SUM_W'(SUM_MAX))))
    else $error("block sum exceeds 25 full-scale samples");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_OUT) && out_tvalid_r && !out_tready) |=> (state_r == S_OUT))
    else $error("result left the core while the output register was full");
`endif

endmodule

// ===== sim/rmf_tb_pkg.sv =====
// rmf_tb_pkg.sv - command codes shared by the mosaic filter testbench
// and its checker; no dependencies
`timescale 1ns / 1ps

package rmf_tb_pkg;

  typedef enum bit {
    CMD_WRITE = 1'b0,
    CMD_READ  = 1'b1
  } pixel_cmd_t;

endpackage

// ===== sim/mosaic_result_checker.sv =====
// mosaic_result_checker.sv - watches the command, result and register ports of the
// rect mosaic filter, predicts every filtered pixel and compares it on transfer
// depends on rmf_pkg and rmf_tb_pkg
`timescale 1ns / 1ps

module mosaic_result_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [rmf_pkg::IN_TDATA_W-1:0] in_tdata,
  input  logic                           in_tuser,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [rmf_pkg::PIX_W-1:0]      out_tdata,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rmf_pkg::APB_AW-1:0]     paddr,
  input  logic [rmf_pkg::APB_DW-1:0]     pwdata,
  input  logic                           pready,
  output int unsigned                    awaiting,
  output int unsigned                    failures
);
  import rmf_pkg::*;
  import rmf_tb_pkg::*;

  bit [PIX_W-1:0]      frame_copy [STORE_DEPTH];
  bit [CFG_DIM_W-1:0]  width_q  = CFG_DIM_W'(MAX_WIDTH);
  bit [CFG_DIM_W-1:0]  height_q = CFG_DIM_W'(MAX_HEIGHT);
  bit [CFG_RECT_W-1:0] left_q   = '0;
  bit [CFG_RECT_W-1:0] right_q  = CFG_RECT_W'(MAX_WIDTH - 1);
  bit [CFG_RECT_W-1:0] top_q    = '0;
  bit [CFG_RECT_W-1:0] bottom_q = CFG_RECT_W'(MAX_HEIGHT - 1);
  bit [PIX_W-1:0]      pending_pixels [$];
  int unsigned         mismatches = 0;

  function automatic int unsigned dim_limit(int unsigned v, int unsigned top_v);
    if (v == 0) return 1;
    if (v > top_v) return top_v;
    return v;
  endfunction

  function automatic bit [PIX_W-1:0] mosaic_pixel(bit [IDX_W-1:0] idx);
    int unsigned w, h, x, y, x0, y0, row, col, dy, dx, sr, sg, sb;
    bit [PIX_W-1:0] p;
    bit [CH_W-1:0] ar, ag, ab;
    w = dim_limit(width_q, MAX_WIDTH);
    h = dim_limit(height_q, MAX_HEIGHT);
    x = idx % w;
    y = idx / w;
    if (x < left_q || x > right_q || y < top_q || y > bottom_q) return frame_copy[idx];
    x0 = x - x % BLOCK;
    y0 = y - y % BLOCK;
    sr = 0;
    sg = 0;
    sb = 0;
    for (dy = 0; dy < BLOCK; dy++) begin
      row = (y0 + dy >= h) ? h - 1 : y0 + dy;
      for (dx = 0; dx < BLOCK; dx++) begin
        col = (x0 + dx >= w) ? w - 1 : x0 + dx;
        p = frame_copy[IDX_W'(row * w + col)];
        sr += p[23:16];
        sg += p[15:8];
        sb += p[7:0];
      end
    end
    ar = CH_W'(sr / (BLOCK * BLOCK));
    ag = CH_W'(sg / (BLOCK * BLOCK));
    ab = CH_W'(sb / (BLOCK * BLOCK));
    return {8'h00, ar, ag, ab};
  endfunction

  always @(posedge clk) begin : watch
    bit [PIX_W-1:0] want;
    if (!rst_n) begin
      pending_pixels.delete();
      width_q  = CFG_DIM_W'(MAX_WIDTH);
      height_q = CFG_DIM_W'(MAX_HEIGHT);
      left_q   = '0;
      right_q  = CFG_RECT_W'(MAX_WIDTH - 1);
      top_q    = '0;
      bottom_q = CFG_RECT_W'(MAX_HEIGHT - 1);
    end else begin
      if (out_tvalid && out_tready) begin
        if (pending_pixels.size() == 0) begin
          $error("filtered_pixel: no transfer expected, actual %h", out_tdata);
          mismatches++;
        end else begin
          want = pending_pixels.pop_front();
          if (out_tdata !== want) begin
            $error("filtered_pixel: expected %h, actual %h", want, out_tdata);
            mismatches++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser == CMD_READ)
          pending_pixels.push_back(mosaic_pixel(in_tdata[IDX_W-1:0]));
        else
          frame_copy[in_tdata[IDX_W-1:0]] = in_tdata[IDX_W +: PIX_W];
      end
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[APB_AW-1:2]))
          REG_FRAME_WIDTH:  width_q  = pwdata[CFG_DIM_W-1:0];
          REG_FRAME_HEIGHT: height_q = pwdata[CFG_DIM_W-1:0];
          REG_RECT_LEFT:    left_q   = pwdata[CFG_RECT_W-1:0];
          REG_RECT_RIGHT:   right_q  = pwdata[CFG_RECT_W-1:0];
          REG_RECT_TOP:     top_q    = pwdata[CFG_RECT_W-1:0];
          REG_RECT_BOTTOM:  bottom_q = pwdata[CFG_RECT_W-1:0];
          default: ;
        endcase
      end
    end
    awaiting <= pending_pixels.size();
    failures <= mismatches;
  end

endmodule

// ===== sim/tb_rect_mosaic_5x5_filter_unit.sv =====
// tb_rect_mosaic_5x5_filter_unit.sv - stimulus for the rect mosaic filter: pixel
// writes, filtered reads over changing frame and rectangle settings, with stalls
// depends on rmf_pkg, rmf_tb_pkg, mosaic_result_checker and the block itself
`timescale 1ns / 1ps

module tb_rect_mosaic_5x5_filter_unit;
  import rmf_pkg::*;
  import rmf_tb_pkg::*;

  localparam int unsigned TOTAL_ITEMS    = 700;
  localparam int unsigned IDLE_PCT       = 9;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned SETTLE_CYCLES  = 64;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned IDX_MAX        = STORE_DEPTH - 1;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic [IN_TDATA_W-1:0] in_tdata  = '0;
  logic                  in_tuser  = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [PIX_W-1:0]      out_tdata;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic                  psel      = 1'b0;
  logic                  penable   = 1'b0;
  logic                  pwrite    = 1'b0;
  logic [APB_AW-1:0]     paddr     = '0;
  logic [APB_DW-1:0]     pwdata    = '0;
  logic [APB_DW-1:0]     prdata;
  logic                  pready;

  int unsigned awaiting_pixels;
  int unsigned check_failures;
  int unsigned sent_items    = 0;
  int unsigned quiet_cycles  = 0;
  bit          no_idle       = 1'b0;
  bit          long_hold_req = 1'b0;
  bit          written [STORE_DEPTH];
  int unsigned reg_shadow [NUM_REGS] =
    '{MAX_WIDTH, MAX_HEIGHT, 0, MAX_WIDTH - 1, 0, MAX_HEIGHT - 1};

  always #4 clk = ~clk;

  rect_mosaic_5x5_filter_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  mosaic_result_checker result_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .awaiting   (awaiting_pixels),
    .failures   (check_failures)
  );

  // receiver: random stalls, one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int unsigned dim_limit(int unsigned v, int unsigned top_v);
    if (v == 0) return 1;
    if (v > top_v) return top_v;
    return v;
  endfunction

  function automatic bit [PIX_W-1:0] rand_pixel();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic set_reg(reg_idx_t r, int unsigned v);
    int unsigned bits;
    bits = (r == REG_FRAME_WIDTH || r == REG_FRAME_HEIGHT) ? CFG_DIM_W : CFG_RECT_W;
    reg_shadow[r] = v & ((1 << bits) - 1);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {r, 2'b00};
    pwdata  <= reg_shadow[r] | ($urandom << bits);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_cmd(pixel_cmd_t cmd, int unsigned idx, bit [PIX_W-1:0] data);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {{(IN_TDATA_W - IDX_W - PIX_W){1'b0}}, data, idx[IDX_W-1:0]};
    do @(posedge clk); while (!in_tready);
    sent_items++;
    if (cmd == CMD_WRITE) written[IDX_W'(idx)] = 1'b1;
  endtask

  task automatic put_pixel(int unsigned idx, bit [PIX_W-1:0] data);
    send_cmd(CMD_WRITE, idx, data);
  endtask

  // writes every pixel the read will touch that holds nothing yet
  task automatic read_pixel(int unsigned idx);
    int unsigned w, h, x, y, x0, y0, row, col, dy, dx, a;
    w = dim_limit(reg_shadow[REG_FRAME_WIDTH], MAX_WIDTH);
    h = dim_limit(reg_shadow[REG_FRAME_HEIGHT], MAX_HEIGHT);
    x = idx % w;
    y = idx / w;
    if (x < reg_shadow[REG_RECT_LEFT] || x > reg_shadow[REG_RECT_RIGHT] ||
        y < reg_shadow[REG_RECT_TOP] || y > reg_shadow[REG_RECT_BOTTOM]) begin
      if (!written[IDX_W'(idx)]) put_pixel(idx, rand_pixel());
    end else begin
      x0 = x - x % BLOCK;
      y0 = y - y % BLOCK;
      for (dy = 0; dy < BLOCK; dy++) begin
        row = (y0 + dy >= h) ? h - 1 : y0 + dy;
        for (dx = 0; dx < BLOCK; dx++) begin
          col = (x0 + dx >= w) ? w - 1 : x0 + dx;
          a = row * w + col;
          if (!written[IDX_W'(a)]) put_pixel(a, rand_pixel());
        end
      end
    end
    send_cmd(CMD_READ, idx, $urandom);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (awaiting_pixels != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic directed_checks();
    put_pixel(0, '1);
    put_pixel(IDX_MAX, '0);
    // corner block clamped at the right and bottom edges
    read_pixel(IDX_MAX);
    drain_results();
    // zero sizes act as one: every block collapses onto pixel 0
    set_reg(REG_FRAME_WIDTH, 0);
    set_reg(REG_FRAME_HEIGHT, 0);
    read_pixel(0);
    read_pixel(7);
    // row far past the frame height, outside the rectangle
    read_pixel(IDX_MAX);
    put_pixel(0, 32'h5a_c3_81_7e);
    read_pixel(3);
    drain_results();
    // empty rectangle, left above right
    set_reg(REG_RECT_LEFT, 9);
    set_reg(REG_RECT_RIGHT, 3);
    read_pixel(0);
    drain_results();
    // oversized frame saturates, single-pixel rectangle at the far corner
    set_reg(REG_FRAME_WIDTH, 1023);
    set_reg(REG_FRAME_HEIGHT, 1023);
    set_reg(REG_RECT_LEFT, 511);
    set_reg(REG_RECT_RIGHT, 511);
    set_reg(REG_RECT_TOP, 511);
    set_reg(REG_RECT_BOTTOM, 511);
    read_pixel(IDX_MAX);
    read_pixel(IDX_MAX - 1);
    drain_results();
    // empty rectangle, top above bottom
    set_reg(REG_RECT_TOP, 20);
    set_reg(REG_RECT_BOTTOM, 10);
    read_pixel(IDX_MAX);
    drain_results();
  endtask

  task automatic pick_config(int unsigned phase);
    int unsigned w, h, l, t;
    case (phase)
      0:       begin w = 1023; h = 1023; end
      1:       begin w = 0;    h = 0;    end
      2:       begin w = 513;  h = 1;    end
      default: begin w = $urandom_range(1, 16); h = $urandom_range(1, 16); end
    endcase
    set_reg(REG_FRAME_WIDTH, w);
    set_reg(REG_FRAME_HEIGHT, h);
    case ($urandom_range(5))
      0: begin
        set_reg(REG_RECT_LEFT, 0);
        set_reg(REG_RECT_RIGHT, 511);
        set_reg(REG_RECT_TOP, 0);
        set_reg(REG_RECT_BOTTOM, 511);
      end
      1: begin
        l = $urandom_range(1, 20);
        set_reg(REG_RECT_LEFT, l);
        set_reg(REG_RECT_RIGHT, $urandom_range(0, l - 1));
        set_reg(REG_RECT_TOP, 0);
        set_reg(REG_RECT_BOTTOM, 511);
      end
      default: begin
        l = $urandom_range(0, 15);
        t = $urandom_range(0, 15);
        set_reg(REG_RECT_LEFT, l);
        set_reg(REG_RECT_RIGHT, l + $urandom_range(0, 10));
        set_reg(REG_RECT_TOP, t);
        set_reg(REG_RECT_BOTTOM, t + $urandom_range(0, 10));
      end
    endcase
  endtask

  task automatic random_phases();
    int unsigned phase, phase_end, w, h, frame, span, idx;
    phase = 0;
    while (sent_items < TOTAL_ITEMS) begin
      drain_results();
      pick_config(phase);
      w = dim_limit(reg_shadow[REG_FRAME_WIDTH], MAX_WIDTH);
      h = dim_limit(reg_shadow[REG_FRAME_HEIGHT], MAX_HEIGHT);
      frame = w * h;
      span = (frame + 2 * w > STORE_DEPTH) ? STORE_DEPTH : frame + 2 * w;
      phase_end = sent_items + ((frame > 1000) ? 40 : $urandom_range(40, 90));
      no_idle = (phase == 3);
      if (phase == 1) long_hold_req = 1'b1;
      while (sent_items < phase_end) begin
        case ($urandom_range(9))
          0:       idx = $urandom_range(0, IDX_MAX);
          1:       idx = $urandom_range(1) ? frame - 1 : 0;
          default: idx = $urandom_range(0, span - 1);
        endcase
        if ($urandom_range(99) < 35) put_pixel(idx, rand_pixel());
        else read_pixel(idx);
        if ($urandom_range(99) == 0) drain_results();
      end
      phase++;
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_checks();
    random_phases();
    no_idle = 1'b0;
    drain_results();
    if (check_failures == 0 && awaiting_pixels == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
